// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the positional insert/remove array.
// Depends on nothing; a file that uses them must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

// Plain invariant.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

`endif

// ===== rtl/core/pira_pkg.sv =====
// Package for the positional insert/remove array: sizes, command and error codes,
// and the control struct broadcast to the cell row. Depends on nothing.
`timescale 1ns / 1ps

package pira_pkg;

	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int CMD_W      = 3;
	localparam int POS_W      = 7;
	localparam int VAL_W      = 32;
	localparam int ERR_W      = 2;
	localparam int COUNT_W    = 7;
	localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ   = 3'd0,
		CMD_SET    = 3'd1,
		CMD_PUSH   = 3'd2,
		CMD_POP    = 3'd3,
		CMD_INSERT = 3'd4,
		CMD_REMOVE = 3'd5
	} cmd_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK    = 2'd0,
		ERR_RANGE = 2'd1,
		ERR_EMPTY = 2'd2,
		ERR_FULL  = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_WRITE,
		OP_SHIFT_UP,
		OP_SHIFT_DOWN
	} cell_op_t;

	typedef struct packed {
		cell_op_t              op;
		logic [IDX_W-1:0]      pos;
		logic [IDX_W-1:0]      rd_pos;
		logic [DATA_WIDTH-1:0] data;
	} cell_ctrl_t;

endpackage

// ===== rtl/core/pira_cell.sv =====
// One storage cell of the array row: holds a data word, takes a new word, its
// lower neighbor's word or its upper neighbor's word. Depends on pira_pkg.
`timescale 1ns / 1ps

module pira_cell import pira_pkg::*; (
	input  logic                  clk,
	input  cell_ctrl_t            ctrl,
	input  logic [IDX_W-1:0]      index,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic [DATA_WIDTH-1:0] right_data,
	output logic [DATA_WIDTH-1:0] data,
	output logic [DATA_WIDTH-1:0] rd_data
);

	logic [DATA_WIDTH-1:0] data_q;
	logic                  hit;
	logic                  above;

	assign hit   = (ctrl.pos == index);
	assign above = (index > ctrl.pos);

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_WRITE: begin
				if (hit) begin
					data_q <= ctrl.data;
				end
			end
			OP_SHIFT_UP: begin
				if (hit) begin
					data_q <= ctrl.data;
				end else if (above) begin
					data_q <= left_data;
				end
			end
			OP_SHIFT_DOWN: begin
				// The removed entry and everything above it take the upper neighbor.
				if (hit || above) begin
					data_q <= right_data;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data    = data_q;
	assign rd_data = (ctrl.rd_pos == index) ? data_q : '0;

endmodule

// ===== rtl/core/pira_ctrl.sv =====
// Command decode, bounds checks, live count and result registers of the
// positional insert/remove array. Depends on pira_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pira_ctrl import pira_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [CMD_W-1:0]      command,
	input  logic [POS_W-1:0]      position,
	input  logic [VAL_W-1:0]      value,
	input  logic [DATA_WIDTH-1:0] read_data,
	output cell_ctrl_t            ctrl,
	output logic                  done,
	output logic [VAL_W-1:0]      read_value,
	output logic [ERR_W-1:0]      error,
	output logic [COUNT_W-1:0]    count
);

	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] fill_d;
	logic             done_q;
	logic [VAL_W-1:0] read_value_q;
	err_t             error_q;
	err_t             err;
	cell_op_t         op;
	logic             rd_ok;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] fill_x;
	logic             full;
	logic             empty;
	logic [IDX_W-1:0] cell_pos;

	assign pos_x  = CMP_W'(position);
	assign fill_x = CMP_W'(fill_q);
	assign full   = (fill_q == CNT_W'(CAPACITY));
	assign empty  = (fill_q == '0);

	always_comb begin
		err      = ERR_OK;
		op       = OP_HOLD;
		rd_ok    = 1'b0;
		fill_d   = fill_q;
		cell_pos = IDX_W'(position);
		unique case (cmd_t'(command))
			CMD_READ: begin
				if (pos_x >= fill_x) begin
					err = ERR_RANGE;
				end else begin
					rd_ok = 1'b1;
				end
			end
			CMD_SET: begin
				if (pos_x >= fill_x) begin
					err = ERR_RANGE;
				end else begin
					op = OP_WRITE;
				end
			end
			CMD_PUSH: begin
				cell_pos = IDX_W'(fill_q);
				if (full) begin
					err = ERR_FULL;
				end else begin
					op     = OP_WRITE;
					fill_d = fill_q + 1'b1;
				end
			end
			CMD_POP: begin
				if (empty) begin
					err = ERR_EMPTY;
				end else begin
					fill_d = fill_q - 1'b1;
				end
			end
			CMD_INSERT: begin
				// Position is checked before fullness; position equal to count appends.
				if (pos_x > fill_x) begin
					err = ERR_RANGE;
				end else if (full) begin
					err = ERR_FULL;
				end else begin
					op     = OP_SHIFT_UP;
					fill_d = fill_q + 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (empty) begin
					err = ERR_EMPTY;
				end else if (pos_x >= fill_x) begin
					err = ERR_RANGE;
				end else begin
					op     = OP_SHIFT_DOWN;
					fill_d = fill_q - 1'b1;
				end
			end
			default: begin
				err = ERR_OK;
			end
		endcase
	end

	assign ctrl.op     = accept ? op : OP_HOLD;
	assign ctrl.pos    = cell_pos;
	assign ctrl.rd_pos = IDX_W'(position);
	assign ctrl.data   = value[DATA_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				fill_q <= fill_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			error_q      <= err;
			read_value_q <= rd_ok ? VAL_W'(read_data) : '0;
		end
	end

	assign done       = done_q;
	assign read_value = read_value_q;
	assign error      = error_q;
	assign count      = COUNT_W'(fill_q);

	`ASSERT_ALWAYS(a_fill_bound, fill_q <= CNT_W'(CAPACITY), "live count above capacity")
	`ASSERT_NEXT(a_result_follows, accept, done_q, "accepted command gave no result")
	`ASSERT_IMPLY(a_fail_keeps_fill, done_q && error_q != ERR_OK, fill_q == $past(fill_q),
		"failed command changed the count")
	`ASSERT_IMPLY(a_fill_step, done_q, fill_q == $past(fill_q) || fill_q == $past(fill_q) + 1'b1
		|| fill_q == $past(fill_q) - 1'b1, "count moved by more than one")
	`ASSERT_IMPLY(a_rd_only_read, done_q && read_value_q != '0,
		$past(command) == CMD_READ && error_q == ERR_OK, "read value on a non-read result")

endmodule

// ===== rtl/core/positional_insert_remove_array.sv =====
// Top level of the positional insert/remove array: the control unit and the
// row of storage cells. Depends on pira_pkg, pira_ctrl and pira_cell.
//
// Usage. A command transfer happens at a rising edge where start is high and
// busy is low; busy is always low, so one command can be given every cycle.
// The command field selects read, set, push, pop, insert or remove, with
// position and value as operands. Exactly one result follows each command,
// in the next cycle: done is high for that cycle with read_value, error and
// count. A result is shown for that single cycle and the receiver cannot
// hold it off, so it must take it when done is high.
// Throughput is one command per cycle. Insert and remove shift each cell at
// or above the position toward its neighbor in the same edge; a read goes
// through a select across all cells, which sets the longest path.
// Reset clears the count to zero; the cell contents are left as they are and
// cannot be read until written. A failed command leaves contents and count
// unchanged and reports its error code.
`timescale 1ns / 1ps

module positional_insert_remove_array import pira_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [CMD_W-1:0]   command,
	input  logic [POS_W-1:0]   position,
	input  logic [VAL_W-1:0]   value,
	output logic               done,
	output logic [VAL_W-1:0]   read_value,
	output logic [ERR_W-1:0]   error,
	output logic [COUNT_W-1:0] count
);

	cell_ctrl_t            ctrl;
	logic                  accept;
	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];
	logic [DATA_WIDTH-1:0] read_data;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	pira_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.command    (command),
		.position   (position),
		.value      (value),
		.read_data  (read_data),
		.ctrl       (ctrl),
		.done       (done),
		.read_value (read_value),
		.error      (error),
		.count      (count)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		pira_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.index      (IDX_W'(i)),
			.left_data  (cell_data[(i == 0) ? i : i - 1]),
			.right_data (cell_data[(i == CAPACITY - 1) ? i : i + 1]),
			.data       (cell_data[i]),
			.rd_data    (cell_rd[i])
		);
	end

	// Only the addressed cell drives a nonzero word, so the read is an OR across the row.
	always_comb begin
		read_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			read_data = read_data | cell_rd[i];
		end
	end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for positional_insert_remove_array: directed and random command
// streams, checked against an in-bench array predictor kept in a small scoreboard class.
// Depends on pira_pkg and the RTL of positional_insert_remove_array.
`timescale 1ns / 1ps

module tb import pira_pkg::*; ;

	localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
	localparam int CYCLE_LIMIT   = 40000;
	localparam int RANDOM_ITEMS  = 1200;
	localparam int PHASE_LEN     = 200;
	localparam int IDLE_PCT      = 16;
	localparam int SETTLE_CYCLES = 4;
	localparam int REPORT_MAX    = 10;

	typedef enum int {PHASE_GROW, PHASE_SHRINK, PHASE_MIXED} phase_t;

	typedef struct packed {
		logic [VAL_W-1:0]   read_value;
		logic [ERR_W-1:0]   error;
		logic [COUNT_W-1:0] count;
	} array_result_t;

	class array_scoreboard;
		logic [DATA_WIDTH-1:0] slots [CAPACITY];
		int unsigned           fill;
		array_result_t         pending_q [$];
		int unsigned           failures;

		function new();
			fill = 0;
			failures = 0;
			foreach (slots[i]) slots[i] = '0;
		endfunction

		// Applies one accepted command to the shadow array and queues its result.
		function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
				logic [VAL_W-1:0] val);
			array_result_t res;
			int unsigned   p;
			res = '0;
			p = pos;
			case (cmd)
				CMD_READ: begin
					if (p >= fill) res.error = ERR_RANGE;
					else res.read_value = VAL_W'(slots[p]);
				end
				CMD_SET: begin
					if (p >= fill) res.error = ERR_RANGE;
					else slots[p] = val[DATA_WIDTH-1:0];
				end
				CMD_PUSH: begin
					if (fill >= CAPACITY) res.error = ERR_FULL;
					else begin
						slots[fill] = val[DATA_WIDTH-1:0];
						fill++;
					end
				end
				CMD_POP: begin
					if (fill == 0) res.error = ERR_EMPTY;
					else fill--;
				end
				CMD_INSERT: begin
					// The position is checked before fullness.
					if (p > fill) res.error = ERR_RANGE;
					else if (fill >= CAPACITY) res.error = ERR_FULL;
					else begin
						for (int i = fill; i > p; i--) slots[i] = slots[i-1];
						slots[p] = val[DATA_WIDTH-1:0];
						fill++;
					end
				end
				CMD_REMOVE: begin
					// Emptiness is checked before the position.
					if (fill == 0) res.error = ERR_EMPTY;
					else if (p >= fill) res.error = ERR_RANGE;
					else begin
						for (int i = p; i + 1 < fill; i++) slots[i] = slots[i+1];
						fill--;
					end
				end
				default: ;
			endcase
			res.count = COUNT_W'(fill);
			pending_q = {pending_q, res};
		endfunction

		function void check_result(array_result_t got);
			array_result_t want;
			if (pending_q.size() == 0) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("ERROR: result with no command outstanding: rd=%h err=%0d cnt=%0d",
						got.read_value, got.error, got.count);
				return;
			end
			want = pending_q.pop_front();
			if (got.read_value !== want.read_value || got.error !== want.error ||
					got.count !== want.count) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("ERROR: result mismatch: expected rd=%h err=%0d cnt=%0d, got rd=%h err=%0d cnt=%0d",
						want.read_value, want.error, want.count,
						got.read_value, got.error, got.count);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [CMD_W-1:0]   command;
	logic [POS_W-1:0]   position;
	logic [VAL_W-1:0]   value;
	logic               done;
	logic [VAL_W-1:0]   read_value;
	logic [ERR_W-1:0]   error;
	logic [COUNT_W-1:0] count;

	array_scoreboard sb;
	bit              idle_on;
	int unsigned     cycle_count;

	positional_insert_remove_array u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.position   (position),
		.value      (value),
		.done       (done),
		.read_value (read_value),
		.error      (error),
		.count      (count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	// Results are checked before the command of the same edge is noted, since a result
	// always belongs to an earlier transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_result(array_result_t'({read_value, error, count}));
			if (start && !busy) sb.note_command(command, position, value);
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val);
		while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			start <= 1'b0;
			@(posedge clk);
			@(negedge clk);
		end
		start    <= 1'b1;
		command  <= cmd;
		position <= pos;
		value    <= val;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	function automatic logic [POS_W-1:0] pick_position(int unsigned fill);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) return (fill == 0) ? '0 : POS_W'($urandom_range(0, fill - 1));
		if (r < 80) return POS_W'(fill);
		if (r < 90) return POS_W'($urandom_range(0, 127));
		case ($urandom_range(0, 3))
			0:       return POS_W'(0);
			1:       return POS_W'(CAPACITY - 1);
			2:       return POS_W'(CAPACITY);
			default: return '1;
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10) return '0;
		if (r < 20) return '1;
		return VAL_W'($urandom);
	endfunction

	// In the grow and shrink phases the weights lean toward growth or shrinkage so that the array reaches full and empty.
	function automatic logic [CMD_W-1:0] pick_command(phase_t phase);
		int unsigned r;
		int unsigned w_push, w_insert, w_pop, w_remove, w_read, w_set;
		case (phase)
			PHASE_GROW: begin
				w_push = 35; w_insert = 25; w_pop = 8; w_remove = 7; w_read = 12; w_set = 10;
			end
			PHASE_SHRINK: begin
				w_push = 8; w_insert = 8; w_pop = 30; w_remove = 30; w_read = 12; w_set = 10;
			end
			default: begin
				w_push = 17; w_insert = 17; w_pop = 15; w_remove = 15; w_read = 18; w_set = 15;
			end
		endcase
		r = $urandom_range(0, 99);
		if (r < w_push) return CMD_PUSH;
		r -= w_push;
		if (r < w_insert) return CMD_INSERT;
		r -= w_insert;
		if (r < w_pop) return CMD_POP;
		r -= w_pop;
		if (r < w_remove) return CMD_REMOVE;
		r -= w_remove;
		if (r < w_read) return CMD_READ;
		r -= w_read;
		if (r < w_set) return CMD_SET;
		return $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
	endfunction

	initial begin
		phase_t phase;
		arst_n   = 1'b0;
		start    = 1'b0;
		command  = CMD_READ;
		position = '0;
		value    = '0;
		idle_on  = 1'b1;
		sb = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty array: every command that needs an entry must fail.
		send_command(CMD_READ, 7'd0, '0);
		send_command(CMD_POP, 7'd0, '0);
		send_command(CMD_REMOVE, 7'd0, '0);
		send_command(CMD_SET, 7'd0, '1);
		send_command(CMD_INSERT, 7'd1, 32'h1111_1111);
		send_command(CMD_INSERT, 7'd0, '1);
		send_command(CMD_PUSH, '1, '0);
		send_command(CMD_PUSH, 7'd0, 32'hA5A5_5A5A);
		// Insert at the count appends; insert in the middle shifts.
		send_command(CMD_INSERT, 7'd3, 32'h0123_4567);
		send_command(CMD_INSERT, 7'd1, 32'h8000_0001);
		for (int i = 0; i < 5; i++) send_command(CMD_READ, POS_W'(i), '1);
		send_command(CMD_SET, 7'd4, 32'hFEDC_BA98);
		send_command(CMD_SET, 7'd5, 32'h5555_5555);
		send_command(CMD_READ, '1, '0);
		send_command(CMD_REMOVE, '1, '0);
		send_command(CMD_REMOVE, 7'd2, '0);
		send_command(CMD_REMOVE, 7'd0, '0);
		send_command(CMD_SPARE_A, 7'd64, '1);
		send_command(CMD_SPARE_B, 7'd0, '0);
		send_command(CMD_POP, 7'd0, '0);
		send_command(CMD_READ, 7'd1, '0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			case ((n / PHASE_LEN) % 3)
				0:       phase = PHASE_GROW;
				1:       phase = PHASE_SHRINK;
				default: phase = PHASE_MIXED;
			endcase
			// One whole phase runs back to back with no gaps.
			idle_on = (n / PHASE_LEN) != 2;
			send_command(pick_command(phase), pick_position(sb.fill), pick_value());
		end
		start <= 1'b0;

		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.pending_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
